>>> src/rde_pkg.sv
package rde_pkg;

  // field widths
  localparam int SYM_W    = 8;
  localparam int DIGIT_W  = 4;
  localparam int COUNT_W  = 6;
  localparam int RADIX_W  = 5;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;

  // alphabet storage
  localparam int NUM_SYMS = 16;
  localparam int TABLE_W  = NUM_SYMS * SYM_W;

  typedef logic [TABLE_W-1:0] sym_table_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RST = 64'h0;
  localparam logic [RADIX_W-1:0] SYMBOL_COUNT_RST = 5'd10;

  // symbols that may not appear in an alphabet
  localparam logic [SYM_W-1:0] PLUS_SIGN  = 8'h2B;
  localparam logic [SYM_W-1:0] MINUS_SIGN = 8'h2D;
  localparam logic [SYM_W-1:0] NUL_SYM    = 8'h00;

  // byte k of the alphabet, symbol 0 in the low byte
  function automatic logic [SYM_W-1:0] sym_at(input sym_table_t tbl,
                                              input logic [DIGIT_W-1:0] k);
    sym_at = tbl[{k, 3'b000} +: SYM_W];
  endfunction

endpackage

>>> src/radix_digit_emitter.sv
// channel   | ports                                       | transfer
// ----------+---------------------------------------------+---------------------------
// input     | start, busy, in_value                       | start high while busy low
// result    | out_strobe, out_symbol, out_is_last,        | every cycle out_strobe high
//           | out_bad_alphabet, out_digit_count           |
// config    | cfg_we, cfg_index, cfg_wdata                | every cycle cfg_we high
//
// An item passes through the alphabet check, symbol by symbol over those in use, then
// one divide pass per digit, and then the replay of its digits. Each digit comes from a
// bit-serial restoring divide, one quotient bit a cycle, and digits are replayed most
// significant first from a digit stack.
// A bad alphabet gives its single result right after the check.
// rst_n is synchronous and restores the alphabet registers; results cannot be stalled.
module radix_digit_emitter #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     in_value,
  output logic                            out_strobe,
  output logic [rde_pkg::SYM_W-1:0]       out_symbol,
  output logic                            out_is_last,
  output logic                            out_bad_alphabet,
  output logic [rde_pkg::COUNT_W-1:0]     out_digit_count,
  input  logic                            cfg_we,
  input  logic [rde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int BIT_W   = $clog2(VALUE_BITS);
  localparam int STACK_W = VALUE_BITS * rde_pkg::DIGIT_W;
  localparam int DW      = rde_pkg::DIGIT_W;
  localparam int RW      = rde_pkg::RADIX_W;
  localparam int CW      = rde_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // configuration registers
  logic [rde_pkg::CFG_W-1:0] sym_low_r, sym_high_r;
  logic [RW-1:0]             sym_count_r;

  // control state
  logic [1:0]      state_r, state_nxt;
  logic [RW-1:0]   radix_r, radix_nxt;
  logic [DW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [BIT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]   nd_r, nd_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic            out_strobe_r, out_strobe_nxt;

  // datapath
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [STACK_W-1:0]    stack_r, stack_nxt;
  logic [rde_pkg::SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic                  out_is_last_r, out_is_last_nxt;
  logic                  out_bad_r, out_bad_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  rde_pkg::sym_table_t   tbl;
  logic [RW-1:0]         radix_clamped;
  logic [rde_pkg::SYM_W-1:0] cur_sym;
  logic                  dup;
  logic                  sym_bad;
  logic                  check_done;
  logic [RW-1:0]         trial;
  logic                  qbit;
  logic [DW-1:0]         rem_step;
  logic [CW-1:0]         nd_inc;

  assign tbl = {sym_high_r, sym_low_r};

  // radix in use, clamped to the symbol limit
  assign radix_clamped = (sym_count_r > RW'(MAX_SYMBOLS)) ? RW'(MAX_SYMBOLS) : sym_count_r;

  // alphabet check of one symbol against every later symbol in use
  assign cur_sym = rde_pkg::sym_at(tbl, chk_idx_r);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < rde_pkg::NUM_SYMS; j++) begin
      if ((RW'(j) > {1'b0, chk_idx_r}) && (RW'(j) < radix_r) &&
          (rde_pkg::sym_at(tbl, DW'(j)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end

  assign sym_bad = (radix_r < RW'(2)) || (cur_sym == rde_pkg::NUL_SYM) ||
                   (cur_sym == rde_pkg::PLUS_SIGN) || (cur_sym == rde_pkg::MINUS_SIGN) || dup;
  assign check_done = ({1'b0, chk_idx_r} + RW'(1)) == radix_r;

  // one restoring divide step
  assign trial    = {rem_r, q_r[VALUE_BITS-1]};
  assign qbit     = (trial >= radix_r);
  assign rem_step = qbit ? DW'(trial - radix_r) : DW'(trial);
  assign nd_inc   = nd_r + CW'(1);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    radix_nxt      = radix_r;
    chk_idx_nxt    = chk_idx_r;
    bit_cnt_nxt    = bit_cnt_r;
    nd_nxt         = nd_r;
    left_nxt       = left_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    stack_nxt      = stack_r;
    out_strobe_nxt = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_is_last_nxt = out_is_last_r;
    out_bad_nxt    = out_bad_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          radix_nxt   = radix_clamped;
          chk_idx_nxt = '0;
          q_nxt       = in_value[VALUE_BITS-1:0];
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sym_bad) begin
          // single error result
          out_strobe_nxt  = 1'b1;
          out_symbol_nxt  = rde_pkg::NUL_SYM;
          out_is_last_nxt = 1'b1;
          out_bad_nxt     = 1'b1;
          out_count_nxt   = '0;
          state_nxt       = ST_IDLE;
        end else if (check_done) begin
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          nd_nxt      = '0;
          state_nxt   = ST_DIV;
        end else begin
          chk_idx_nxt = chk_idx_r + DW'(1);
        end
      end
      ST_DIV: begin
        q_nxt   = {q_r[VALUE_BITS-2:0], qbit};
        rem_nxt = rem_step;
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (bit_cnt_r == BIT_W'(VALUE_BITS - 1)) begin
          // pass done: push the digit, stop once the quotient is zero
          stack_nxt   = {stack_r[STACK_W-DW-1:0], rem_step};
          nd_nxt      = nd_inc;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          if (q_nxt == '0) begin
            left_nxt  = nd_inc;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // pop most significant digit first
        out_strobe_nxt  = 1'b1;
        out_symbol_nxt  = rde_pkg::sym_at(tbl, stack_r[DW-1:0]);
        out_is_last_nxt = (left_r == CW'(1));
        out_bad_nxt     = 1'b0;
        out_count_nxt   = (left_r == CW'(1)) ? nd_r : '0;
        stack_nxt       = {DW'(0), stack_r[STACK_W-1:DW]};
        left_nxt        = left_r - CW'(1);
        if (left_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r   <= rde_pkg::SYMBOLS_LOW_RST;
      sym_high_r  <= rde_pkg::SYMBOLS_HIGH_RST;
      sym_count_r <= rde_pkg::SYMBOL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rde_pkg::REG_SYMBOLS_LOW:  sym_low_r   <= cfg_wdata;
        rde_pkg::REG_SYMBOLS_HIGH: sym_high_r  <= cfg_wdata;
        rde_pkg::REG_SYMBOL_COUNT: sym_count_r <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      radix_r      <= '0;
      chk_idx_r    <= '0;
      bit_cnt_r    <= '0;
      nd_r         <= '0;
      left_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      radix_r      <= radix_nxt;
      chk_idx_r    <= chk_idx_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      nd_r         <= nd_nxt;
      left_r       <= left_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    rem_r         <= rem_nxt;
    stack_r       <= stack_nxt;
    out_symbol_r  <= out_symbol_nxt;
    out_is_last_r <= out_is_last_nxt;
    out_bad_r     <= out_bad_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_symbol       = out_symbol_r;
  assign out_is_last      = out_is_last_r;
  assign out_bad_alphabet = out_bad_r;
  assign out_digit_count  = out_count_r;

endmodule

>>> src/rde_checker.sv
module rde_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [rde_pkg::SYM_W-1:0]   out_symbol,
  input logic                        out_is_last,
  input logic                        out_bad_alphabet,
  input logic [rde_pkg::COUNT_W-1:0] out_digit_count
);

  // a transfer starts work and nothing is shown in the cycle after
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("accepted item did not start work");

  // more digits to come keeps the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |-> busy)
    else $error("non-final result while idle");

  // leading digits carry no count and no error
  a_lead_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_last |-> out_digit_count == '0 && !out_bad_alphabet)
    else $error("leading digit with count or error");

  // error result has the fixed shape
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bad_alphabet |-> out_is_last && out_digit_count == '0 &&
                                       out_symbol == rde_pkg::NUL_SYM)
    else $error("malformed error result");

  // a good final digit reports at least one digit
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_last && !out_bad_alphabet |-> out_digit_count != '0)
    else $error("final digit with zero count");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_symbol       (out_symbol),
  .out_is_last      (out_is_last),
  .out_bad_alphabet (out_bad_alphabet),
  .out_digit_count  (out_digit_count)
);
